[src/lirs_pkg.sv]
package lirs_pkg;

  // sample and fixed-point position format
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 16;
  localparam int STEP_W    = 19;
  localparam int POS_W     = 20;

  // cap on outputs per source gap, and the same cap on the tail
  localparam int MAX_OUT = 8;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] POS_TWO = POS_W'(2) << FRAC_BITS;

  // configuration register map
  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] REG_SOURCE_STEP = 2'd0;
  localparam logic [STEP_W-1:0] STEP_RESET      = STEP_W'(65536);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       run_end;
    logic                       stream_end;
  } out_beat_t;

endpackage

[src/lirs_mul.sv]
module lirs_mul (
  input  logic                           clk,
  input  logic [lirs_pkg::SAMPLE_W-1:0]  mag,
  input  logic [lirs_pkg::FRAC_BITS-1:0] frac,
  output logic [lirs_pkg::SAMPLE_W-1:0]  prod_hi
);

  logic [lirs_pkg::SAMPLE_W+lirs_pkg::FRAC_BITS-1:0] prod;

  // magnitude times fraction, truncated toward zero
  assign prod = {{lirs_pkg::FRAC_BITS{1'b0}}, mag} *
                {{lirs_pkg::SAMPLE_W{1'b0}}, frac};

  always_ff @(posedge clk) begin
    prod_hi <= prod[lirs_pkg::SAMPLE_W+lirs_pkg::FRAC_BITS-1:lirs_pkg::FRAC_BITS];
  end

endmodule

[src/linear_interp_resampler_core.sv]
// Linear-interpolation resampler: each input beat carries one 16-bit source sample; a Q16
// position accumulator advances by source_step (register 0, Q16, reset 1.0) per output, and
// every output whose position falls between the previous sample and this one is emitted as
// prev + trunc(frac * (cur - prev)), left and right equal. The first sample of a stream only
// primes the state. On a beat marked last_sample the outputs up to one sample past it are
// also emitted holding that sample, and the stream state returns to reset. run_end flags the
// last output of each input beat, stream_end the final output of the stream. At most 8
// outputs come from one gap and 8 from the tail. The block takes one beat at a time
// (in_ready only while idle). Each interpolated output of a beat passes through the shared
// registered multiplier and then through the add into the output register; each tail
// output goes straight into the output register, and both wait while the output side
// stalls. The output register lets the block finish a beat while its last result is
// still waiting to be taken.
module linear_interp_resampler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lirs_pkg::in_beat_t            in_data,
  // output beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output lirs_pkg::out_beat_t           out_data,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lirs_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an input beat
  localparam logic [1:0] ST_MUL  = 2'd1;  // multiplier works on the current position
  localparam logic [1:0] ST_EMIT = 2'd2;  // interpolated value goes to the output register
  localparam logic [1:0] ST_TAIL = 2'd3;  // outputs after the last sample, holding it

  localparam int SW = lirs_pkg::SAMPLE_W;
  localparam int PW = lirs_pkg::POS_W;
  localparam int CW = lirs_pkg::CNT_W;

  logic [1:0]                     state_r, state_nxt;
  logic [lirs_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [SW-1:0]                  prev_r, prev_nxt;
  logic                           have_prev_r, have_prev_nxt;
  logic [PW-1:0]                  pos_r, pos_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [SW-1:0]                  base_r, base_nxt;   // start sample of the gap
  logic [SW-1:0]                  cur_r, cur_nxt;     // sample of the beat at work
  logic [SW-1:0]                  mag_r, mag_nxt;     // |cur - base|
  logic                           neg_r, neg_nxt;
  logic                           last_r, last_nxt;
  logic                           out_valid_r, out_valid_nxt;
  lirs_pkg::out_beat_t            out_r, out_nxt;

  logic [SW-1:0]                  prod_hi;
  logic                           in_fire;
  logic                           cfg_wr;
  logic                           slot_free;
  logic [PW-1:0]                  pos_step;
  logic [CW-1:0]                  cnt_inc;
  logic                           more;
  logic [PW-1:0]                  pos_adj;
  logic                           tail_go;
  logic [SW:0]                    diff;
  logic [SW:0]                    diff_mag;
  logic [SW:0]                    lerp_sum;
  logic [SW-1:0]                  lerp_val;

  // shared multiplier, registered output
  lirs_mul u_mul (
    .clk     (clk),
    .mag     (mag_r),
    .frac    (pos_r[lirs_pkg::FRAC_BITS-1:0]),
    .prod_hi (prod_hi)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr == lirs_pkg::REG_SOURCE_STEP);

  always_comb begin
    if (paddr == lirs_pkg::REG_SOURCE_STEP) begin
      prdata = {{(32 - lirs_pkg::STEP_W){1'b0}}, step_r};
    end else begin
      prdata = '0;
    end
  end

  // lookahead: position after this output, and what follows it
  assign slot_free = !out_valid_r || out_ready;
  assign pos_step  = pos_r + {{(PW - lirs_pkg::STEP_W){1'b0}}, step_r};
  assign cnt_inc   = cnt_r + CW'(1);
  assign more      = (pos_step < lirs_pkg::POS_ONE) && (cnt_inc < CW'(lirs_pkg::MAX_OUT));
  // a gap that ends below one sample was cut by the cap, position restarts at zero
  assign pos_adj   = (pos_step < lirs_pkg::POS_ONE) ? '0 : pos_step - lirs_pkg::POS_ONE;
  // the tail emits at least once when the adjusted position is below one sample
  assign tail_go   = pos_step < lirs_pkg::POS_TWO;

  // difference of the new sample to the previous one, as sign and magnitude
  assign diff      = {in_data.sample[SW-1], in_data.sample} - {prev_r[SW-1], prev_r};
  assign diff_mag  = diff[SW] ? (~diff + (SW+1)'(1)) : diff;

  // base plus or minus the truncated product never leaves the sample range
  assign lerp_sum  = neg_r ? ({base_r[SW-1], base_r} - {1'b0, prod_hi})
                           : ({base_r[SW-1], base_r} + {1'b0, prod_hi});
  assign lerp_val  = lerp_sum[SW-1:0];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    cur_nxt       = cur_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    last_nxt      = last_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_wr) begin
      step_nxt = pwdata[lirs_pkg::STEP_W-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cur_nxt  = in_data.sample;
          last_nxt = in_data.last_sample;
          base_nxt = prev_r;
          neg_nxt  = diff[SW];
          mag_nxt  = diff_mag[SW-1:0];
          cnt_nxt  = '0;
          // a last beat leaves the stream state at reset
          prev_nxt      = in_data.last_sample ? '0 : in_data.sample;
          have_prev_nxt = !in_data.last_sample;
          if (!have_prev_r) begin
            // first sample of a stream
            pos_nxt = '0;
            if (in_data.last_sample) begin
              state_nxt = ST_TAIL;
            end
          end else if (pos_r < lirs_pkg::POS_ONE) begin
            state_nxt = ST_MUL;
          end else if (in_data.last_sample && (pos_r < lirs_pkg::POS_TWO)) begin
            // gap empty, tail still has outputs
            pos_nxt   = pos_r - lirs_pkg::POS_ONE;
            state_nxt = ST_TAIL;
          end else if (in_data.last_sample) begin
            pos_nxt = '0;
          end else begin
            // step past the whole gap
            pos_nxt = pos_r - lirs_pkg::POS_ONE;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.left_out   = lerp_val;
          out_nxt.right_out  = lerp_val;
          out_nxt.run_end    = !more && !(last_r && tail_go);
          out_nxt.stream_end = !more && last_r && !tail_go;
          if (more) begin
            pos_nxt   = pos_step;
            cnt_nxt   = cnt_inc;
            state_nxt = ST_MUL;
          end else if (last_r && tail_go) begin
            pos_nxt   = pos_adj;
            cnt_nxt   = '0;
            state_nxt = ST_TAIL;
          end else if (last_r) begin
            pos_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt   = pos_adj;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.left_out   = cur_r;
          out_nxt.right_out  = cur_r;
          out_nxt.run_end    = !more;
          out_nxt.stream_end = !more;
          if (more) begin
            pos_nxt = pos_step;
            cnt_nxt = cnt_inc;
          end else begin
            pos_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= lirs_pkg::STEP_RESET;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    cur_r  <= cur_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
    out_r  <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  // stream end is always also the end of its beat's run
  a_stream_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.stream_end || out_r.run_end))
    else $error("stream_end without run_end");

  // both channels carry the same value
  a_left_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.left_out == out_r.right_out))
    else $error("left and right differ");

  // a last beat clears the stream state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last_sample) |=> !have_prev_r)
    else $error("stream state kept after last sample");

  // the multiplier only ever sees a position below one sample
  a_mul_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (pos_r < lirs_pkg::POS_ONE))
    else $error("interpolation position out of range");
`endif

endmodule
